FILE: design/isort_pkg.sv
`default_nettype none
package isort_pkg;

    localparam int DEPTH = 64;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // Broadcast to every cell
    typedef struct packed {
        logic  insert;
        logic  shift;
        t_word word;
    } t_cell_ctrl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic  occ;
        logic  gt;
        t_word value;
    } t_cell_state;

endpackage
`default_nettype wire

FILE: design/isort_if.sv
`default_nettype none
interface isort_in_if;
    logic                valid;
    logic                ready;
    isort_pkg::t_word    value;
    logic                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
    logic                valid;
    logic                ready;
    isort_pkg::t_word    sorted_value;
    logic                end_of_run;
    logic                overflowed;

    modport source (output valid, output sorted_value, output end_of_run,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input overflowed, output ready);
endinterface
`default_nettype wire

FILE: design/insertion_sorter.sv
// A request is taken every cycle while no drain runs.
// The request with last set starts a drain: one result per cycle from the cell
// row head while the receiver is ready, fill count results in all, input ready
// held low until the final one.
// Reset (synchronous, active low) empties every cell and clears drain/drop state.
`default_nettype none
module insertion_sorter (
    input  wire          i_clk,
    input  wire          i_rst_n,
    isort_in_if.sink     i_in,
    isort_out_if.source  o_out
);

    logic r_drain;
    logic n_drain;
    logic r_dropped;
    logic n_dropped;

    isort_pkg::t_cell_ctrl  w_ctrl;
    isort_pkg::t_cell_state w_cells [isort_pkg::DEPTH];
    isort_pkg::t_cell_state w_prev  [isort_pkg::DEPTH];
    isort_pkg::t_cell_state w_next  [isort_pkg::DEPTH];
    logic [isort_pkg::DEPTH-1:0] w_occ;

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;
    logic w_eor;

    assign i_in.ready = !r_drain;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_full     = w_occ[isort_pkg::DEPTH-1];
    assign w_eor      = !w_occ[1];

    assign o_out.valid        = r_drain && w_occ[0];
    assign o_out.sorted_value = w_cells[0].value;
    assign o_out.end_of_run   = w_eor;
    assign o_out.overflowed   = r_dropped;
    assign w_out_acc          = o_out.valid && o_out.ready;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;
    assign w_ctrl.word   = i_in.value;

    genvar g;
    generate
        for (g = 0; g < isort_pkg::DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = '{occ: 1'b1, gt: 1'b0, value: '0};
            end else begin : g_body
                assign w_prev[g] = w_cells[g-1];
            end
            if (g == isort_pkg::DEPTH-1) begin : g_tail
                assign w_next[g] = '{occ: 1'b0, gt: 1'b1, value: '0};
            end else begin : g_mid
                assign w_next[g] = w_cells[g+1];
            end
            assign w_occ[g] = w_cells[g].occ;

            isort_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_prev  (w_prev[g]),
                .i_next  (w_next[g]),
                .o_state (w_cells[g])
            );
        end
    endgenerate

    always_comb begin
        n_drain   = r_drain;
        n_dropped = r_dropped;
        if (w_in_acc) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_in.last) begin
                n_drain = 1'b1;
            end
        end
        if (w_out_acc && w_eor) begin
            n_drain   = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_drain   <= n_drain;
            r_dropped <= n_dropped;
        end
    end

    // Occupied cells always form a contiguous run from the head.
    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_occ} + (isort_pkg::DEPTH+1)'(1)))
        else $error("cell occupancy not contiguous");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert |=> $countones(w_occ) == $past($countones(w_occ)) + 1)
        else $error("insert did not add one cell");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_eor) |=> (!r_drain && (w_occ == '0) && !r_dropped))
        else $error("drain end left state behind");

    a_drop_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full) |=> r_dropped)
        else $error("dropped request not recorded");

endmodule
`default_nettype wire

FILE: design/isort_cell.sv
`default_nettype none
module isort_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  isort_pkg::t_cell_ctrl   i_ctrl,
    input  isort_pkg::t_cell_state  i_prev,
    input  isort_pkg::t_cell_state  i_next,
    output isort_pkg::t_cell_state  o_state
);

    logic             r_occ;
    isort_pkg::t_word r_value;
    logic             n_occ;
    isort_pkg::t_word n_value;
    logic             w_gt;

    // Empty cells count as greater than anything; strict compare keeps ties stable.
    assign w_gt = !r_occ || (r_value > i_ctrl.word);

    always_comb begin
        n_occ   = r_occ;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_occ   = i_next.occ;
            n_value = i_next.value;
        end else if (i_ctrl.insert && w_gt) begin
            if (i_prev.gt) begin
                n_occ   = i_prev.occ;
                n_value = i_prev.value;
            end else begin
                n_occ   = 1'b1;
                n_value = i_ctrl.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_state.occ   = r_occ;
    assign o_state.gt    = w_gt;
    assign o_state.value = r_value;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int PHASE_ITEMS  = 40;

    typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SINK_STALLS, PH_BOTH} t_phase;

    typedef struct packed {
        isort_pkg::t_word value;
        logic             eor;
        logic             ovf;
    } t_sorted_result;

    typedef struct {
        isort_pkg::t_word value;
        logic             last;
        logic             pinned;
        t_sorted_result   want;
    } t_step_row;

    localparam t_sorted_result NO_RESULT = '0;

    logic i_clk;
    logic i_rst_n;

    isort_in_if  in_if ();
    isort_out_if out_if ();

    insertion_sorter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state
    isort_pkg::t_word sorted_store [isort_pkg::DEPTH];
    int             store_fill;
    logic           store_dropped;
    t_sorted_result pending_results [$];
    t_sorted_result head_result;

    int src_gap_pct;
    int sink_stall_pct;
    int cycle_count;
    int n_errors;
    int n_requests;
    int n_sets;
    int n_overflow_sets;
    int n_checked;

    // Single-element sets are pinned; the rest go through the predictor
    t_step_row directed_rows [23] = '{
        '{32'sh7FFF_FFFF, 1'b1, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
        '{32'sh8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
        '{32'sd0,         1'b1, 1'b1, '{32'sd0,         1'b1, 1'b0}},
        '{-32'sd1,        1'b1, 1'b1, '{-32'sd1,        1'b1, 1'b0}},
        '{32'sd1,         1'b1, 1'b1, '{32'sd1,         1'b1, 1'b0}},
        // mixed set with duplicates and both extremes
        '{32'sd5,         1'b0, 1'b0, NO_RESULT},
        '{-32'sd3,        1'b0, 1'b0, NO_RESULT},
        '{32'sd5,         1'b0, 1'b0, NO_RESULT},
        '{32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
        '{-32'sd3,        1'b0, 1'b0, NO_RESULT},
        '{32'sd0,         1'b0, 1'b0, NO_RESULT},
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
        '{32'sh8000_0000, 1'b1, 1'b0, NO_RESULT},
        // descending arrival
        '{32'sd3,         1'b0, 1'b0, NO_RESULT},
        '{32'sd2,         1'b0, 1'b0, NO_RESULT},
        '{32'sd1,         1'b0, 1'b0, NO_RESULT},
        '{32'sd0,         1'b0, 1'b0, NO_RESULT},
        '{-32'sd1,        1'b1, 1'b0, NO_RESULT},
        // ascending arrival
        '{-32'sd2,        1'b0, 1'b0, NO_RESULT},
        '{-32'sd1,        1'b0, 1'b0, NO_RESULT},
        '{32'sd0,         1'b0, 1'b0, NO_RESULT},
        '{32'sd1,         1'b1, 1'b0, NO_RESULT}
    };

    t_phase phase_order [4] = '{PH_STEADY, PH_SRC_GAPS, PH_SINK_STALLS, PH_BOTH};

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL insertion_sorter");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: sorted_value %0d end_of_run %0b overflowed %0b",
                       out_if.sorted_value, out_if.end_of_run, out_if.overflowed);
                n_errors++;
            end else begin
                head_result = pending_results.pop_front();
                n_checked++;
                if (out_if.sorted_value !== head_result.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           head_result.value, out_if.sorted_value);
                    n_errors++;
                end
                if (out_if.end_of_run !== head_result.eor) begin
                    $error("end_of_run: expected %0b, got %0b",
                           head_result.eor, out_if.end_of_run);
                    n_errors++;
                end
                if (out_if.overflowed !== head_result.ovf) begin
                    $error("overflowed: expected %0b, got %0b",
                           head_result.ovf, out_if.overflowed);
                    n_errors++;
                end
            end
        end
    end

    // Stable insert: a new word goes after every stored word equal to it
    function automatic void file_word(input isort_pkg::t_word w);
        int pos;
        if (store_fill >= isort_pkg::DEPTH) begin
            store_dropped = 1'b1;
            return;
        end
        pos = store_fill;
        while (pos > 0 && sorted_store[pos-1] > w)
            pos--;
        for (int k = store_fill; k > pos; k--)
            sorted_store[k] = sorted_store[k-1];
        sorted_store[pos] = w;
        store_fill++;
    endfunction

    function automatic void sort_step(input isort_pkg::t_word w, input logic l);
        file_word(w);
        if (l) begin
            n_sets++;
            if (store_dropped)
                n_overflow_sets++;
            for (int k = 0; k < store_fill; k++)
                pending_results.push_back(t_sorted_result'{sorted_store[k],
                                          k == store_fill - 1, store_dropped});
            store_fill    = 0;
            store_dropped = 1'b0;
        end
    endfunction

    function automatic isort_pkg::t_word random_word();
        case ($urandom_range(9)) inside
            [4:6]:   return isort_pkg::t_word'(int'($urandom_range(8)) - 4);
            7:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:       return 32'sh8000_0000 + isort_pkg::t_word'($urandom_range(3));
            9:       return 32'sh7FFF_FFFF - isort_pkg::t_word'($urandom_range(3));
            default: return isort_pkg::t_word'($urandom);
        endcase
    endfunction

    // Called and returns at a falling edge; valid is left high after the request
    task automatic push_request(input isort_pkg::t_word w, input logic l,
                                input logic pinned, input t_sorted_result want);
        int base;
        while ($urandom_range(99) < src_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= w;
        in_if.last  <= l;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        n_requests++;
        base = pending_results.size();
        sort_step(w, l);
        if (pinned) begin
            while (pending_results.size() > base)
                void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge i_clk);
    endtask

    task automatic send_set(input int count);
        for (int k = 0; k < count; k++)
            push_request(random_word(), k == count - 1, 1'b0, NO_RESULT);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6, 1);
        if (r < 92)
            return $urandom_range(16, 7);
        return $urandom_range(40, 17);
    endfunction

    initial begin
        int phase_start;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.value    = '0;
        in_if.last     = 1'b0;
        out_if.ready   = 1'b0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        cycle_count    = 0;
        n_errors       = 0;
        n_requests     = 0;
        n_sets         = 0;
        n_overflow_sets = 0;
        n_checked      = 0;
        store_fill     = 0;
        store_dropped  = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            push_request(directed_rows[i].value, directed_rows[i].last,
                         directed_rows[i].pinned, directed_rows[i].want);
        wait_drained();

        foreach (phase_order[p]) begin
            case (phase_order[p])
                PH_STEADY:      begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                PH_SRC_GAPS:    begin src_gap_pct = 48; sink_stall_pct = 0;  end
                PH_SINK_STALLS: begin src_gap_pct = 0;  sink_stall_pct = 48; end
                PH_BOTH:        begin src_gap_pct = 25; sink_stall_pct = 25; end
            endcase
            phase_start = n_requests;
            while (n_requests - phase_start < PHASE_ITEMS)
                send_set(pick_set_size());
            // one set per phase around capacity: exactly full, last one dropped,
            // several dropped, one short of full
            case (phase_order[p])
                PH_STEADY:      send_set(isort_pkg::DEPTH);
                PH_SRC_GAPS:    send_set(isort_pkg::DEPTH + 1);
                PH_SINK_STALLS: send_set(isort_pkg::DEPTH + 6);
                PH_BOTH:        send_set(isort_pkg::DEPTH - 1);
            endcase
            phase_start = n_requests;
            while (n_requests - phase_start < 10)
                send_set(pick_set_size());
            // hold the sender until the block has drained everything
            wait_drained();
        end

        repeat (2 * isort_pkg::DEPTH + 16) @(posedge i_clk);

        $display("Sorted %0d requests in %0d sets (%0d with dropped values), %0d results checked",
                 n_requests, n_sets, n_overflow_sets, n_checked);
        $display("Ran with no idling, sender gaps, receiver stalls and both together");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("PASS insertion_sorter");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("FAIL insertion_sorter");
        end
        $finish;
    end

endmodule

FILE: files.f
design/isort_pkg.sv
design/isort_if.sv
design/isort_cell.sv
design/insertion_sorter.sv
test/tb_top.sv
